@@ rtl/core/bha_pkg.sv @@
// Shared constants and types for the bucket histogram accumulator.
`timescale 1ns / 1ps

package bha_pkg;

    localparam int NUM_BOUNDS = 6;
    localparam int BIDX_W     = 3;
    localparam int CNT_W      = 32;
    localparam int SUM_W      = 64;
    localparam int SAMPLE_W   = 32;
    localparam int STAMP_W    = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BIDX_W-1:0] NB_LIMIT = BIDX_W'(NUM_BOUNDS);

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_FIRST = 3'd1;

    localparam logic FUNC_OBSERVE = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    typedef enum logic [1:0] {
        KIND_BUCKET = 2'd0,
        KIND_INF    = 2'd1,
        KIND_SUM    = 2'd2,
        KIND_COUNT  = 2'd3
    } kind_t;

endpackage

@@ rtl/core/bucket_histogram_accumulator_unit.sv @@
// Top level of the bucket histogram accumulator: observe path, read-out sequencer, output register.
`timescale 1ns / 1ps

// Observe items are taken one per cycle while the unit is idle: the bucket counter is read from
// the counter RAM in the accept cycle and written back, saturated, in the next, with a bypass
// register covering a read that meets the write to the same bucket. Sum and total count live in
// flip-flops and update in the accept cycle. A read item stops input acceptance while the
// sequencer walks the RAM: for each bucket in use a RAM read, then load of the output register
// and clear of the entry; then a sweep clearing the buckets not in use; then the beats for the
// +Inf total, sum and count. Stalls on the output side stretch this; the next item is taken once
// the count beat is loaded. After reset a clearing pass zeroes the counter RAM before the first
// item is taken.
module bucket_histogram_accumulator_unit (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    input  logic                                     func,
    input  logic signed [bha_pkg::SAMPLE_W-1:0]      sample,
    input  logic [bha_pkg::STAMP_W-1:0]              stamp,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    output bha_pkg::kind_t                           kind,
    output logic [bha_pkg::BIDX_W-1:0]               bucket_index,
    output logic signed [bha_pkg::SUM_W-1:0]         amount,
    output logic [bha_pkg::STAMP_W-1:0]              stamp_out,
    output logic                                     last,
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [bha_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [bha_pkg::CFG_DATA_W-1:0]           cfg_data
);

    import bha_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_RREQ  = 8'b00000010,
        ST_RWAIT = 8'b00000100,
        ST_CLR   = 8'b00001000,
        ST_TOT   = 8'b00010000,
        ST_SUM   = 8'b00100000,
        ST_CNT   = 8'b01000000,
        ST_INIT  = 8'b10000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [BIDX_W-1:0]            idx_reg, idx_next;

    logic [BIDX_W-1:0]            bound_count_reg;
    logic signed [SAMPLE_W-1:0]   bound_reg [NUM_BOUNDS];
    logic [BIDX_W-1:0]            n_in_use;

    logic [CNT_W-1:0]             total_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [SUM_W:0]               sum_ext;
    logic signed [SUM_W-1:0]      sum_sat;

    logic                         b_valid_reg;
    logic [BIDX_W-1:0]            b_idx_reg;

    logic                         hit;
    logic [BIDX_W-1:0]            hit_idx;

    logic                         in_fire, obs_fire, rd_fire;
    logic                         out_free;

    logic                         ram_we, ram_re;
    logic [BIDX_W-1:0]            ram_waddr, ram_raddr;
    logic [CNT_W-1:0]             ram_wdata, ram_rdata;
    logic                         byp_valid_reg;
    logic [CNT_W-1:0]             byp_data_reg;
    logic [CNT_W-1:0]             cnt_eff;
    logic [CNT_W-1:0]             cnt_inc;

    logic [STAMP_W-1:0]           stamp_hold_reg;

    logic                         out_valid_reg;
    kind_t                        out_kind_reg;
    logic [BIDX_W-1:0]            out_bidx_reg;
    logic signed [SUM_W-1:0]      out_amount_reg;
    logic [STAMP_W-1:0]           out_stamp_reg;
    logic                         out_last_reg;

    logic                         load;
    kind_t                        load_kind;
    logic [BIDX_W-1:0]            load_bidx;
    logic signed [SUM_W-1:0]      load_amount;
    logic                         load_last;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign obs_fire  = in_fire && (func == FUNC_OBSERVE);
    assign rd_fire   = in_fire && (func == FUNC_READ);
    assign out_free  = !out_valid_reg || out_ready;

    assign n_in_use = (bound_count_reg > NB_LIMIT) ? NB_LIMIT : bound_count_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_count_reg <= '0;
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                bound_reg[i] <= '0;
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BOUND_COUNT)
            begin
                bound_count_reg <= cfg_data[BIDX_W-1:0];
            end
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                if (cfg_index == CFG_BOUND_FIRST + CFG_IDX_W'(i))
                begin
                    bound_reg[i] <= cfg_data;
                end
            end
        end
    end

    // First bound in register order above the sample wins
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_BOUNDS - 1; i >= 0; i--)
        begin
            if ((BIDX_W'(i) < n_in_use) && (sample < bound_reg[i]))
            begin
                hit     = 1'b1;
                hit_idx = BIDX_W'(i);
            end
        end
    end

    // Counter RAM access
    assign cnt_eff = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign cnt_inc = (cnt_eff == '1) ? cnt_eff : cnt_eff + CNT_W'(1);

    always_comb
    begin
        ram_re    = (obs_fire && hit) || (state_reg == ST_RREQ);
        ram_raddr = (state_reg == ST_RREQ) ? idx_reg : hit_idx;
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = '0;
        priority if (b_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = b_idx_reg;
            ram_wdata = cnt_inc;
        end
        else if (state_reg == ST_RWAIT)
        begin
            ram_we = out_free;
        end
        else if (state_reg == ST_CLR)
        begin
            ram_we = (idx_reg < NB_LIMIT);
        end
        else if (state_reg == ST_INIT)
        begin
            ram_we = 1'b1;
        end
    end

    bha_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BOUNDS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Catch a write landing on the entry being read in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
            b_valid_reg   <= 1'b0;
        end
        else
        begin
            if (ram_re)
            begin
                byp_valid_reg <= ram_we && (ram_waddr == ram_raddr);
            end
            b_valid_reg <= obs_fire && hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            byp_data_reg <= ram_wdata;
        end
        b_idx_reg <= hit_idx;
        if (rd_fire)
        begin
            stamp_hold_reg <= stamp;
        end
    end

    // Running sum with signed saturation
    assign sum_ext = {sum_reg[SUM_W-1], sum_reg}
                   + {{(SUM_W - SAMPLE_W + 1){sample[SAMPLE_W-1]}}, sample};

    always_comb
    begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1])
        begin
            sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            sum_sat = sum_ext[SUM_W-1:0];
        end
    end

    // Read-out sequencer
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        load        = 1'b0;
        load_kind   = KIND_BUCKET;
        load_bidx   = '0;
        load_amount = '0;
        load_last   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                // zero every counter entry once after reset
                if (idx_reg == NB_LIMIT - BIDX_W'(1))
                begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + BIDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (rd_fire)
                begin
                    idx_next   = '0;
                    state_next = (n_in_use == '0) ? ST_CLR : ST_RREQ;
                end
            end
            ST_RREQ:
            begin
                state_next = ST_RWAIT;
            end
            ST_RWAIT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_bidx   = idx_reg;
                    load_amount = {{(SUM_W-CNT_W){1'b0}}, cnt_eff};
                    idx_next    = idx_reg + BIDX_W'(1);
                    state_next  = (idx_reg == n_in_use - BIDX_W'(1)) ? ST_CLR : ST_RREQ;
                end
            end
            ST_CLR:
            begin
                // sweep the buckets not in use
                if (idx_reg >= NB_LIMIT - BIDX_W'(1))
                begin
                    state_next = ST_TOT;
                end
                else
                begin
                    idx_next = idx_reg + BIDX_W'(1);
                end
            end
            ST_TOT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_kind   = KIND_INF;
                    load_amount = {{(SUM_W-CNT_W){1'b0}}, total_reg};
                    state_next  = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_kind   = KIND_SUM;
                    load_amount = sum_reg;
                    state_next  = ST_CNT;
                end
            end
            ST_CNT:
            begin
                if (out_free)
                begin
                    load        = 1'b1;
                    load_kind   = KIND_COUNT;
                    load_amount = {{(SUM_W-CNT_W){1'b0}}, total_reg};
                    load_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (obs_fire)
            begin
                total_reg <= (total_reg == '1) ? total_reg : total_reg + CNT_W'(1);
                sum_reg   <= sum_sat;
            end
            else if (load && load_last)
            begin
                total_reg <= '0;
                sum_reg   <= '0;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the stamp with the beat, so a following read cannot change it
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg   <= load_kind;
            out_bidx_reg   <= load_bidx;
            out_amount_reg <= load_amount;
            out_stamp_reg  <= stamp_hold_reg;
            out_last_reg   <= load_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign bucket_index = out_bidx_reg;
    assign amount       = out_amount_reg;
    assign stamp_out    = out_stamp_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (b_idx_reg < n_in_use))
        else $error("counter write-back outside the buckets in use");

    a_no_wb_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !b_valid_reg)
        else $error("observe write-back overlaps read-out");

    a_bucket_beat_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg == KIND_BUCKET)) |-> (out_bidx_reg < n_in_use))
        else $error("bucket beat index beyond bounds in use");

    a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && load_last) |=> ((total_reg == '0) && (sum_reg == '0)))
        else $error("total or sum not cleared after read-out");
`endif

endmodule

@@ rtl/core/bha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
